// ===== sv/pip_pkg.sv =====
// Package for the point-in-polygon tester: vertex store sizing, command codes
// and coordinate types. No dependencies; used by pip_in_if and all modules.

package pip_pkg;

	// Vertex store depth and derived widths
	localparam int MAX_VERTICES = 64;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);

	// Coordinate widths (degrees times 1e7)
	localparam int X_W = 32;
	localparam int Y_W = 31;

	// Shared multiplier operand and product widths
	localparam int MUL_W  = X_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	typedef logic signed [X_W-1:0]    coord_x_t;
	typedef logic signed [Y_W-1:0]    coord_y_t;
	typedef logic signed [MUL_W-1:0]  mul_op_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [VIDX_W-1:0]        vidx_t;
	typedef logic [VCNT_W-1:0]        vcnt_t;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEST   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

endpackage

// ===== sv/pip_in_if.sv =====
// Request channel of the point-in-polygon tester: command and coordinates.
// Depends on pip_pkg for the field types.

interface pip_in_if;
	logic              valid;
	logic              ready;
	pip_pkg::cmd_t     cmd;
	pip_pkg::coord_x_t coord_x;
	pip_pkg::coord_y_t coord_y;

	modport source (output valid, output cmd, output coord_x, output coord_y, input ready);
	modport sink   (input valid, input cmd, input coord_x, input coord_y, output ready);
endinterface

// ===== sv/pip_out_if.sv =====
// Response channel of the point-in-polygon tester: inside flag and status.
// No package dependency.

interface pip_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic status;

	modport source (output valid, output inside_res, output status, input ready);
	modport sink   (input valid, input inside_res, input status, output ready);
endinterface

// ===== sv/pip_mul.sv =====
// Shared signed multiplier of the point-in-polygon tester, product registered.
// Depends on pip_pkg for operand and product types.

module pip_mul (
	input  logic             clk,
	input  logic             en,
	input  pip_pkg::mul_op_t a,
	input  pip_pkg::mul_op_t b,
	output pip_pkg::prod_t   p
);

	pip_pkg::prod_t p_q;

	// Multiply and hold the product until the next enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= pip_pkg::PROD_W'(a) * pip_pkg::PROD_W'(b);
		end
	end

	assign p = p_q;

endmodule

// ===== sv/point_in_polygon_test.sv =====
// Top level of the even-odd ray-casting point-in-polygon tester.
// Depends on pip_pkg, pip_in_if, pip_out_if and pip_mul.
//
// Usage:
//   req carries one command per beat: clear polygon, append vertex (x, y)
//   or test point (x, y). rsp returns exactly one beat per request beat:
//   inside_res (test only) and status (1 when an append hit a full store).
//   Clear, append and unused codes give their response one cycle after the
//   request beat. A test walks the ring one edge at a time: it fetches the
//   first vertex, then for each stored edge runs a span check, two passes
//   through the one shared 33x33 multiplier and a compare. A test of an
//   empty polygon answers as clear and append do. The store is a RAM with
//   one write and one read port, read one vertex per cycle; the shared
//   multiplier sets the length of each edge step.
//   req.ready is high only while no test is running and the response
//   register is empty or being taken in the same cycle, so a stalled
//   receiver holds the response and blocks the next request beat.
//   Reset empties the polygon (vertex count zero) and the response
//   register; store contents are not cleared and an unwritten entry is never used.

module point_in_polygon_test (
	input  logic       clk,
	input  logic       arst_n,
	pip_in_if.sink     req,
	pip_out_if.source  rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_FIRST,
		ST_SPAN,
		ST_MUL_L,
		ST_MUL_R,
		ST_CMP
	} state_t;

	state_t             state_q;
	pip_pkg::vcnt_t     count_q;
	pip_pkg::vcnt_t     k_q;
	pip_pkg::coord_x_t  px_q, first_x_q, prev_x_q, rdx_q;
	pip_pkg::coord_y_t  py_q, first_y_q, prev_y_q, rdy_q;
	pip_pkg::mul_op_t   dxp_q, dx_q;
	logic signed [pip_pkg::Y_W:0] dy_q, dyp_q;
	pip_pkg::prod_t     lhs_q;
	logic               span_q, vert_q, dypos_q, parity_q;
	logic               out_valid_q, inside_q, status_q;

	// Vertex store
	pip_pkg::coord_x_t  xmem [pip_pkg::MAX_VERTICES];
	pip_pkg::coord_y_t  ymem [pip_pkg::MAX_VERTICES];

	logic               accept, wr_en, store_full;
	logic               rsp_load;
	pip_pkg::vidx_t     rd_addr;
	pip_pkg::vcnt_t     k_next;
	logic               last_edge;
	pip_pkg::coord_x_t  cur_x, xhi;
	pip_pkg::coord_y_t  cur_y, ylo, yhi;
	logic               span_ok, hit;
	pip_pkg::mul_op_t   mul_a, mul_b;
	logic               mul_en;
	pip_pkg::prod_t     prod;

	// Handshake and store control
	assign req.ready  = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept     = req.valid && req.ready;
	assign store_full = (count_q == pip_pkg::VCNT_W'(pip_pkg::MAX_VERTICES));
	assign wr_en      = accept && (req.cmd == pip_pkg::CMD_APPEND) && !store_full;

	// Read the vertex after the current edge's start, or the first one
	assign k_next    = k_q + 1'b1;
	assign rd_addr   = (state_q == ST_FETCH) ? '0 : k_next[pip_pkg::VIDX_W-1:0];
	assign last_edge = (k_next == count_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			xmem[count_q[pip_pkg::VIDX_W-1:0]] <= req.coord_x;
			ymem[count_q[pip_pkg::VIDX_W-1:0]] <= req.coord_y;
		end
		rdx_q <= xmem[rd_addr];
		rdy_q <= ymem[rd_addr];
	end

	// Edge end point: close the ring back to the first vertex
	assign cur_x   = last_edge ? first_x_q : rdx_q;
	assign cur_y   = last_edge ? first_y_q : rdy_q;
	assign ylo     = (prev_y_q < cur_y) ? prev_y_q : cur_y;
	assign yhi     = (prev_y_q < cur_y) ? cur_y : prev_y_q;
	assign xhi     = (prev_x_q < cur_x) ? cur_x : prev_x_q;
	assign span_ok = (py_q > ylo) && (py_q <= yhi) && (px_q <= xhi);

	// Shared multiplier: (px - x1) * dy, then (py - y1) * (x2 - x1)
	assign mul_en = (state_q == ST_MUL_L) || (state_q == ST_MUL_R);
	assign mul_a  = (state_q == ST_MUL_L) ? dxp_q : dx_q;
	assign mul_b  = (state_q == ST_MUL_L) ? pip_pkg::MUL_W'(dy_q) : pip_pkg::MUL_W'(dyp_q);

	pip_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Crossing test with the comparison sense set by the sign of dy
	assign hit = span_q && (vert_q || (dypos_q ? (lhs_q <= prod) : (lhs_q >= prod)));

	// Load a response on a short command, an empty-polygon test or the last edge
	assign rsp_load = (accept && !((req.cmd == pip_pkg::CMD_TEST) && (count_q != '0))) ||
			((state_q == ST_CMP) && (k_q == count_q));

	// Sequencer, vertex count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
			status_q    <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			dxp_q       <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			dyp_q       <= '0;
			lhs_q       <= '0;
			span_q      <= 1'b0;
			vert_q      <= 1'b0;
			dypos_q     <= 1'b0;
		end else begin
			// hold the response until taken, raise it when a new one is loaded
			out_valid_q <= rsp_load || (out_valid_q && !rsp.ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						px_q     <= req.coord_x;
						py_q     <= req.coord_y;
						k_q      <= '0;
						parity_q <= 1'b0;
						case (req.cmd)
							pip_pkg::CMD_CLEAR: begin
								count_q     <= '0;
								inside_q    <= 1'b0;
								status_q    <= 1'b0;
							end
							pip_pkg::CMD_APPEND: begin
								if (!store_full) begin
									count_q <= count_q + 1'b1;
								end
								inside_q    <= 1'b0;
								status_q    <= store_full;
							end
							pip_pkg::CMD_TEST: begin
								if (count_q == '0) begin
									inside_q    <= 1'b0;
									status_q    <= 1'b0;
								end else begin
									state_q <= ST_FETCH;
								end
							end
							default: begin
								inside_q    <= 1'b0;
								status_q    <= 1'b0;
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_FIRST;
				end
				ST_FIRST: begin
					first_x_q <= rdx_q;
					first_y_q <= rdy_q;
					prev_x_q  <= rdx_q;
					prev_y_q  <= rdy_q;
					state_q   <= ST_SPAN;
				end
				ST_SPAN: begin
					span_q   <= span_ok;
					vert_q   <= (prev_x_q == cur_x);
					dypos_q  <= (cur_y > prev_y_q);
					dxp_q    <= pip_pkg::MUL_W'(px_q) - pip_pkg::MUL_W'(prev_x_q);
					dx_q     <= pip_pkg::MUL_W'(cur_x) - pip_pkg::MUL_W'(prev_x_q);
					dy_q     <= (pip_pkg::Y_W+1)'(cur_y) - (pip_pkg::Y_W+1)'(prev_y_q);
					dyp_q    <= (pip_pkg::Y_W+1)'(py_q) - (pip_pkg::Y_W+1)'(prev_y_q);
					prev_x_q <= cur_x;
					prev_y_q <= cur_y;
					state_q  <= ST_MUL_L;
				end
				ST_MUL_L: begin
					// advance the edge index early so the next read lands in time
					k_q     <= k_next;
					state_q <= ST_MUL_R;
				end
				ST_MUL_R: begin
					lhs_q   <= prod;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (k_q == count_q) begin
						inside_q    <= parity_q ^ hit;
						status_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						parity_q <= parity_q ^ hit;
						state_q  <= ST_SPAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.inside_res = inside_q;
	assign rsp.status     = status_q;

endmodule
